// ===== hdl/key_scan_debounce_events_top_assert.svh =====
// Assertion macros for the key scan debouncer.
// The first form checks a property that holds at every edge.
// The second form checks that a condition is followed by a consequence in the next cycle.
`ifndef KEY_SCAN_DEBOUNCE_EVENTS_TOP_ASSERT_SVH
`define KEY_SCAN_DEBOUNCE_EVENTS_TOP_ASSERT_SVH
`ifndef SYNTH
`define KSDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("key scan debouncer: assertion failed");
`define KSDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key scan debouncer: assertion failed");
`else
`define KSDE_ASSERT(lbl, prop)
`define KSDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/ksde_pkg.sv =====
package ksde_pkg;

  // Fixed field widths.
  localparam int unsigned SCAN_W = 64;
  localparam int unsigned NOTE_W = 7;

  // Default geometry.
  localparam int unsigned WINDOW_SCANS_DEF   = 8;
  localparam int unsigned KEY_GROUPS_DEF     = 8;
  localparam int unsigned KEYS_PER_GROUP_DEF = 8;

  // Base note after reset.
  localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SWEEP
  } ksde_state_e;

endpackage

// ===== hdl/ksde_scan_if.sv =====
interface ksde_scan_if;
  logic                        valid;
  logic                        ready;
  logic [ksde_pkg::SCAN_W-1:0] scan_bits;

  modport source (output valid, output scan_bits, input ready);
  modport sink (input valid, input scan_bits, output ready);
endinterface

// ===== hdl/ksde_event_if.sv =====
interface ksde_event_if;
  logic                        valid;
  logic                        ready;
  logic [ksde_pkg::NOTE_W-1:0] note_number;
  logic                        note_on;
  logic                        last_event;

  modport source (output valid, output note_number, output note_on, output last_event,
                  input ready);
  modport sink (input valid, input note_number, input note_on, input last_event,
                output ready);
endinterface

// ===== hdl/key_scan_debounce_events_top.sv =====
// A scan that does not end a window is accepted while idle and yields no event.
// A scan that ends a window moves the block to a load state and then a sweep that steps
// over the key indices up to the last changed key, held while an event waits for output.
// Throughput: one scan per cycle inside a window; a window end holds off the next scan
// until the load and the sweep are done, and output stalls lengthen the sweep.
// Reset: asynchronous, active low; all keys released, window empty, base note 48.
`include "key_scan_debounce_events_top_assert.svh"

module key_scan_debounce_events_top #(
  parameter int unsigned WINDOW_SCANS   = ksde_pkg::WINDOW_SCANS_DEF,
  parameter int unsigned KEY_GROUPS     = ksde_pkg::KEY_GROUPS_DEF,
  parameter int unsigned KEYS_PER_GROUP = ksde_pkg::KEYS_PER_GROUP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ksde_pkg::NOTE_W-1:0] cfg_wdata_i,
  ksde_scan_if.sink                   scan_i,
  ksde_event_if.source                event_o
);

  // Number of keys that are actually scanned, and the counter widths that follow.
  localparam int unsigned NKEYS     = KEY_GROUPS * KEYS_PER_GROUP;
  localparam int unsigned KEY_CNT_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int unsigned WIN_W     = $clog2(WINDOW_SCANS);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW_SCANS - 1);

  ksde_pkg::ksde_state_e state_q, state_d;

  logic [WIN_W-1:0]                win_idx_q, win_idx_d;
  logic [NKEYS-1:0]                first_q, first_d;
  logic [KEY_GROUPS-1:0]           stable_q, stable_d;
  logic [NKEYS-1:0]                changes_q, changes_d;
  logic [NKEYS-1:0]                key_state_q, key_state_d;
  logic [KEY_CNT_W-1:0]            key_cnt_q, key_cnt_d;
  logic [ksde_pkg::NOTE_W-1:0]     base_note_q;

  logic                            out_valid_q;
  logic [ksde_pkg::NOTE_W-1:0]     out_note_q;
  logic                            out_on_q;
  logic                            out_last_q;

  logic                            in_ready;
  logic                            in_fire;
  logic                            slot_free;
  logic                            cur_change;
  logic                            emit;
  logic                            advance;
  logic [NKEYS-1:0]                key_onehot;
  logic [NKEYS-1:0]                changes_rest;
  logic [NKEYS-1:0]                stable_bits;
  logic [KEY_GROUPS-1:0]           group_eq;

  // Each group of the incoming scan is compared against the first scan of the window.
  // A group stays stable only while every scan so far matches that first scan, so the
  // window itself never has to be stored.
  always_comb begin
    for (int g = 0; g < KEY_GROUPS; g++) begin
      group_eq[g] = (scan_i.scan_bits[g*KEYS_PER_GROUP +: KEYS_PER_GROUP] ==
                     first_q[g*KEYS_PER_GROUP +: KEYS_PER_GROUP]);
    end
    for (int k = 0; k < NKEYS; k++) begin
      stable_bits[k] = stable_q[k / KEYS_PER_GROUP];
    end
  end

  // The sweep looks at one key per cycle unless a change waits on a busy output slot.
  // The key under the counter is the one whose change bit is read; the remaining change
  // mask tells whether an event found now is the last one of this scan.
  always_comb begin
    key_onehot   = '0;
    key_onehot[key_cnt_q] = 1'b1;
    cur_change   = changes_q[key_cnt_q];
    changes_rest = changes_q & ~key_onehot;
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = (state_q == ksde_pkg::ST_IDLE);
    in_fire   = in_ready && scan_i.valid;
    slot_free = !out_valid_q || event_o.ready;
    emit      = (state_q == ksde_pkg::ST_SWEEP) && cur_change && slot_free;
    advance   = (state_q == ksde_pkg::ST_SWEEP) && (!cur_change || slot_free);
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ksde_pkg::ST_IDLE: begin
        if (in_fire && (win_idx_q == WIN_LAST)) begin
          state_d = ksde_pkg::ST_LOAD;
        end
      end
      ksde_pkg::ST_LOAD: begin
        state_d = ksde_pkg::ST_SWEEP;
      end
      ksde_pkg::ST_SWEEP: begin
        if (changes_q == '0) begin
          state_d = ksde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ksde_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    win_idx_d   = win_idx_q;
    first_d     = first_q;
    stable_d    = stable_q;
    changes_d   = changes_q;
    key_state_d = key_state_q;
    key_cnt_d   = key_cnt_q;

    if (in_fire) begin
      if (win_idx_q == WIN_LAST) begin
        win_idx_d = '0;
      end else begin
        win_idx_d = win_idx_q + 1'b1;
      end
      if (win_idx_q == '0) begin
        // The first scan of a window starts every group off as stable.
        first_d  = scan_i.scan_bits[NKEYS-1:0];
        stable_d = '1;
      end else begin
        stable_d = stable_q & group_eq;
      end
    end

    if (state_q == ksde_pkg::ST_LOAD) begin
      // A key changes when its stable group disagrees with the stored key state.
      changes_d = (first_q ^ key_state_q) & stable_bits;
      key_cnt_d = '0;
    end

    if (advance) begin
      key_cnt_d = key_cnt_q + 1'b1;
    end

    if (emit) begin
      changes_d   = changes_rest;
      key_state_d = key_state_q ^ key_onehot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksde_pkg::ST_IDLE;
      win_idx_q   <= '0;
      changes_q   <= '0;
      key_state_q <= '1;
      key_cnt_q   <= '0;
      base_note_q <= ksde_pkg::BASE_NOTE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_idx_q   <= win_idx_d;
      changes_q   <= changes_d;
      key_state_q <= key_state_d;
      key_cnt_q   <= key_cnt_d;
      if (cfg_we_i) begin
        base_note_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window contents and the output payload need no reset: they are only read after
  // they have been written.
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    stable_q <= stable_d;
    if (emit) begin
      out_note_q <= base_note_q + ksde_pkg::NOTE_W'(key_cnt_q);
      out_on_q   <= ~first_q[key_cnt_q];
      out_last_q <= (changes_rest == '0);
    end
  end

  // The output register decouples the sweep from the event sink: one event transfer
  // per cycle while the sink keeps ready high.
  assign scan_i.ready        = in_ready;
  assign event_o.valid       = out_valid_q;
  assign event_o.note_number = out_note_q;
  assign event_o.note_on     = out_on_q;
  assign event_o.last_event  = out_last_q;

  // The scan that closes a window always starts the evaluation.
  `KSDE_ASSERT_NEXT(a_window_end_loads, in_fire && (win_idx_q == WIN_LAST),
                    state_q == ksde_pkg::ST_LOAD)
  // An emitted key is retired from the change mask and its stored state flips.
  `KSDE_ASSERT_NEXT(a_emit_retires, emit,
                    (changes_q[$past(key_cnt_q)] == 1'b0) &&
                    (key_state_q[$past(key_cnt_q)] != $past(key_state_q[key_cnt_q])))
  // An event flagged last leaves no pending change behind.
  `KSDE_ASSERT_NEXT(a_last_empties, emit && (changes_rest == '0), changes_q == '0)
  // A sweep with nothing left returns to idle.
  `KSDE_ASSERT_NEXT(a_sweep_done, (state_q == ksde_pkg::ST_SWEEP) && (changes_q == '0),
                    state_q == ksde_pkg::ST_IDLE)

endmodule

// ===== verif/key_scan_debounce_events_top_tb.sv =====
module key_scan_debounce_events_top_tb;

  // Geometry of the block under test. The scan window, the key groups and the
  // group width are the package defaults, which the instance below also uses.
  localparam int unsigned WIN_DEPTH  = ksde_pkg::WINDOW_SCANS_DEF;
  localparam int unsigned GROUPS     = ksde_pkg::KEY_GROUPS_DEF;
  localparam int unsigned GROUP_KEYS = ksde_pkg::KEYS_PER_GROUP_DEF;
  localparam int unsigned KEY_COUNT  = GROUPS * GROUP_KEYS;

  // A window end loads once and then sweeps one key per cycle while the output
  // slot is free. SWEEP_CYCLES covers an unstalled load and sweep, so it also
  // covers what is left after the last event. The margin covers the return to idle.
  localparam int unsigned SWEEP_CYCLES  = 2 + KEY_COUNT;
  localparam int unsigned SETTLE_CYCLES = SWEEP_CYCLES + 16;

  // Stimulus size and run limits.
  localparam int unsigned TOTAL_SCANS      = 360;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned MAX_REPORTS      = 100;

  // The upper end of the base note range.
  localparam logic [ksde_pkg::NOTE_W-1:0] BASE_NOTE_TOP = 7'd64;

  // One key event as the block should produce it.
  typedef struct packed {
    logic [ksde_pkg::NOTE_W-1:0] note_number;
    logic                        note_on;
    logic                        last_event;
  } key_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [ksde_pkg::NOTE_W-1:0] cfg_wdata_i;

  ksde_scan_if  scan_ch ();
  ksde_event_if note_ch ();

  key_scan_debounce_events_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .scan_i      (scan_ch.sink),
    .event_o     (note_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the debouncer: the stored scans of the current window, the
  // position of the next scan, the debounced key levels and the base note.
  logic [ksde_pkg::SCAN_W-1:0] scan_hist [WIN_DEPTH];
  int unsigned                 scan_pos;
  logic [ksde_pkg::SCAN_W-1:0] key_levels;
  logic [ksde_pkg::NOTE_W-1:0] base_note;

  // Events that the block still owes, oldest first.
  key_event_t pending_events[$];

  // The scans of the next window to send.
  logic [ksde_pkg::SCAN_W-1:0] window_buf [WIN_DEPTH];

  int unsigned mismatch_count;
  int unsigned scans_sent;
  int unsigned cycle_count;

  // When set, neither side inserts random gaps, so that stretches of
  // back-to-back transfers occur as well.
  bit steady_flow;

  // The long receiver hold-off is run by its own process below.
  event long_hold_go;
  logic long_hold_on;

  function automatic void clear_key_model();
    for (int unsigned k = 0; k < WIN_DEPTH; k++) begin
      scan_hist[k] = '0;
    end
    scan_pos   = 0;
    key_levels = '1;
    base_note  = ksde_pkg::BASE_NOTE_RESET;
  endfunction

  // Stores one scan. On the last scan of a window, every group that held the
  // same bits throughout is compared with the debounced levels, and each key
  // that moved yields one event in ascending key order. Only the final event
  // of the window carries the last flag.
  function automatic void predict_key_events(input logic [ksde_pkg::SCAN_W-1:0] scan);
    int unsigned changed[$];
    int unsigned key;
    logic        stable;
    key_event_t  ev;

    scan_hist[scan_pos] = scan;
    if (scan_pos != WIN_DEPTH - 1) begin
      scan_pos++;
      return;
    end
    scan_pos = 0;

    for (int unsigned g = 0; g < GROUPS; g++) begin
      stable = 1'b1;
      for (int unsigned k = 1; k < WIN_DEPTH; k++) begin
        if (scan_hist[k][g*GROUP_KEYS +: GROUP_KEYS] !=
            scan_hist[0][g*GROUP_KEYS +: GROUP_KEYS]) begin
          stable = 1'b0;
        end
      end
      if (stable) begin
        for (int unsigned i = 0; i < GROUP_KEYS; i++) begin
          key = g * GROUP_KEYS + i;
          if (scan_hist[0][key] != key_levels[key]) begin
            key_levels[key] = scan_hist[0][key];
            changed.push_back(key);
          end
        end
      end
    end

    // The note number wraps at the width of the field.
    for (int unsigned j = 0; j < changed.size(); j++) begin
      ev.note_number = base_note + ksde_pkg::NOTE_W'(changed[j]);
      ev.note_on     = ~key_levels[changed[j]];
      ev.last_event  = (j == changed.size() - 1);
      pending_events.push_back(ev);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s, got %0d, expected %0d",
               cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Gap before a transfer or stall after one: mostly none, often a short gap,
  // and now and then a long stretch.
  function automatic int unsigned pick_gap(input int unsigned short_pct,
                                           input int unsigned long_pct);
    int unsigned r;
    if (steady_flow) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < short_pct) begin
      return $urandom_range(1, 3);
    end
    if (r < short_pct + long_pct) begin
      return $urandom_range(12, 60);
    end
    return 0;
  endfunction

  // Offers one scan and returns at the edge at which it is taken. The valid
  // stays high afterwards, so a following scan with no gap goes out back to
  // back without the valid being lowered in between.
  task automatic send_scan(input logic [ksde_pkg::SCAN_W-1:0] bits);
    int unsigned gap;
    gap = pick_gap(30, 4);
    if (gap != 0) begin
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    scan_ch.valid     <= 1'b1;
    scan_ch.scan_bits <= bits;
    @(posedge clk_i);
    while (!scan_ch.ready) @(posedge clk_i);
    predict_key_events(bits);
    scans_sent++;
  endtask

  task automatic send_window();
    for (int unsigned s = 0; s < WIN_DEPTH; s++) begin
      send_scan(window_buf[s]);
    end
  endtask

  // Fills every scan of the window with one value.
  task automatic fill_window(input logic [ksde_pkg::SCAN_W-1:0] bits);
    for (int unsigned s = 0; s < WIN_DEPTH; s++) begin
      window_buf[s] = bits;
    end
  endtask

  // Builds a well-formed window: each group settles on a level that keeps,
  // nudges or replaces its present debounced level, and some groups bounce
  // in one or more scans, which must keep them from being taken.
  task automatic build_window(input int unsigned bounce_pct);
    logic [GROUP_KEYS-1:0] level;
    logic [GROUP_KEYS-1:0] noise;
    int unsigned           sel;
    int unsigned           pos;
    for (int unsigned g = 0; g < GROUPS; g++) begin
      level = key_levels[g*GROUP_KEYS +: GROUP_KEYS];
      sel = $urandom_range(9);
      if (sel >= 3 && sel < 7) begin
        level = level ^ (GROUP_KEYS'(1) << $urandom_range(GROUP_KEYS - 1));
        if (sel == 6) begin
          level = level ^ (GROUP_KEYS'(1) << $urandom_range(GROUP_KEYS - 1));
        end
      end else if (sel >= 7) begin
        level = GROUP_KEYS'($urandom_range(255));
      end
      for (int unsigned s = 0; s < WIN_DEPTH; s++) begin
        window_buf[s][g*GROUP_KEYS +: GROUP_KEYS] = level;
      end
      if ($urandom_range(99) < bounce_pct) begin
        repeat ($urandom_range(1, 3)) begin
          pos   = $urandom_range(WIN_DEPTH - 1);
          noise = GROUP_KEYS'($urandom_range(1, 255));
          window_buf[pos][g*GROUP_KEYS +: GROUP_KEYS] = level ^ noise;
        end
      end
    end
  endtask

  // Lowers the valid and waits until every owed event has been taken, then
  // lets the block finish any sweep that emits nothing more.
  task automatic wait_idle();
    scan_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base_note(input logic [ksde_pkg::NOTE_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    base_note = value;
    cfg_we_i <= 1'b0;
  endtask

  // All keys pressed at once from the reset state: the most events one
  // window can cause, numbered from the reset base note.
  task automatic test_reset_full_press();
    fill_window('0);
    send_window();
    wait_idle();
  endtask

  // Groups that bounce in the first, a middle and the last scan are skipped.
  // The other groups either keep their level or release some keys, and the
  // top group reaches note 127 at the highest base note.
  task automatic test_unstable_groups();
    write_base_note(BASE_NOTE_TOP);
    fill_window(64'hA5C3_3C81_FF7E_9600);
    window_buf[0][15:8]  = window_buf[0][15:8] ^ 8'h01;
    window_buf[3][55:48] = window_buf[3][55:48] ^ 8'hFF;
    window_buf[7][39:32] = window_buf[7][39:32] ^ 8'h80;
    send_window();
    wait_idle();
  endtask

  // Every key released with the base note at zero, so key zero gives note 0.
  task automatic test_base_zero_release();
    write_base_note('0);
    fill_window('1);
    send_window();
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while windows that flip every
  // key keep coming. The event side fills, the sweep stops, and the block
  // has to stall the scan side until the receiver drains it.
  task automatic test_output_backpressure();
    write_base_note(7'd48);
    steady_flow = 1'b1;
    -> long_hold_go;
    repeat (4) begin
      fill_window(~key_levels);
      send_window();
    end
    steady_flow = 1'b0;
    wait_idle();
  endtask

  // Mostly well-formed windows with random content, some pure noise windows,
  // and a new base note between phases, the range ends among them.
  task automatic test_random_windows();
    int unsigned windows_in_phase;
    logic [ksde_pkg::NOTE_W-1:0] next_base;
    windows_in_phase = 0;
    while (scans_sent < TOTAL_SCANS) begin
      if (windows_in_phase == 6) begin
        case ($urandom_range(3))
          0:       next_base = '0;
          1:       next_base = BASE_NOTE_TOP;
          default: next_base = ksde_pkg::NOTE_W'($urandom_range(0, 64));
        endcase
        write_base_note(next_base);
        steady_flow = ($urandom_range(3) == 0);
        windows_in_phase = 0;
      end
      if ($urandom_range(9) == 0) begin
        for (int unsigned s = 0; s < WIN_DEPTH; s++) begin
          window_buf[s] = {$urandom, $urandom};
        end
      end else begin
        build_window(25);
      end
      send_window();
      windows_in_phase++;
    end
    steady_flow = 1'b0;
  endtask

  // The event receiver. Stalls are drawn after each ready cycle, and the long
  // hold-off overrides everything while it runs.
  initial begin : note_sink
    int unsigned stall_left;
    stall_left = 0;
    note_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_on) begin
        note_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        note_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        note_ch.ready <= 1'b1;
        stall_left = pick_gap(15, 2);
      end
    end
  end

  // Counts out the long hold-off in cycles once a test asks for it.
  initial begin : long_hold
    long_hold_on <= 1'b0;
    forever begin
      @(long_hold_go);
      @(posedge clk_i);
      long_hold_on <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      long_hold_on <= 1'b0;
    end
  end

  // Every event transfer is checked against the oldest owed event.
  always @(posedge clk_i) begin : event_check
    key_event_t want;
    if (rst_ni === 1'b1 && note_ch.valid === 1'b1 && note_ch.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with none owed, note", 32'(note_ch.note_number), 0);
      end else begin
        want = pending_events.pop_front();
        if (note_ch.note_number !== want.note_number) begin
          report_mismatch("note_number", 32'(note_ch.note_number),
                          32'(want.note_number));
        end
        if (note_ch.note_on !== want.note_on) begin
          report_mismatch("note_on", 32'(note_ch.note_on), 32'(want.note_on));
        end
        if (note_ch.last_event !== want.last_event) begin
          report_mismatch("last_event", 32'(note_ch.last_event), 32'(want.last_event));
        end
      end
    end
  end

  // The slowest correct run stays far below this limit; reaching it means the
  // block hung or lost events.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("key_scan_debounce_events_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    scans_sent     = 0;
    steady_flow    = 1'b0;
    clear_key_model();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    scan_ch.valid     <= 1'b0;
    scan_ch.scan_bits <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_full_press();
    test_unstable_groups();
    test_base_zero_release();
    test_output_backpressure();
    test_random_windows();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("key_scan_debounce_events_top_tb: done, clean");
    end else begin
      $display("key_scan_debounce_events_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ksde_pkg.sv
hdl/ksde_scan_if.sv
hdl/ksde_event_if.sv
hdl/key_scan_debounce_events_top.sv
verif/key_scan_debounce_events_top_tb.sv
